// ----- src/first_fit_page_allocator_core_macros.svh -----
// Assertion macros for the first-fit page allocator core.
// Used by the top level; needs clk and rst_n in scope.
`ifndef FIRST_FIT_PAGE_ALLOCATOR_CORE_MACROS_SVH
`define FIRST_FIT_PAGE_ALLOCATOR_CORE_MACROS_SVH
`define FFPA_ASSERT_IMP(name, ante, cons) \
  name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("ffpa assertion failed");
`define FFPA_ASSERT_NXT(name, ante, cons) \
  name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("ffpa assertion failed");
`endif

// ----- src/ffpa_pkg.sv -----
// Shared types and constants of the first-fit page allocator.
// No dependencies.
`timescale 1ns / 1ps
package ffpa_pkg;
  localparam int MAX_BLOCKS_DEF = 256;
  localparam int PAGE_BYTES_DEF = 4096;
  localparam int AW = 48;
  localparam int PG_W = 20;
  localparam int OFF_W = 21;
  localparam int NEED_W = 33;
  localparam int TOTAL_W = 11;
  localparam logic [PG_W-1:0] PAGES_RESET = 20'hFFFFF;
  localparam logic [1:0] JOIN_LEFT = 2'b01;
  localparam logic [1:0] JOIN_RIGHT = 2'b10;
  localparam logic [1:0] JOIN_BOTH = 2'b11;
  localparam logic [3:0] REG_BASE = 4'h0;
  localparam logic [3:0] REG_PAGES = 4'h8;

  typedef enum logic [1:0] {
    ST_OK = 2'd0,
    ST_NOFIT = 2'd1,
    ST_RANGE = 2'd2,
    ST_NOSTART = 2'd3
  } status_t;

  typedef enum logic [2:0] {
    S_IDLE, S_PREP, S_LAUNCH, S_SCAN, S_APPLY, S_DONE
  } state_t;

  typedef struct packed {
    logic valid;
    logic [OFF_W-1:0] off;
    logic found;
    logic [OFF_W-1:0] hit_off;
    logic split;
    logic [1:0] join_lr;
  } tok_t;

  typedef struct packed {
    logic init;
    logic clr;
    logic apply;
    logic is_free;
    logic room;
    logic [NEED_W-1:0] need;
    logic [OFF_W-1:0] tgt;
    logic tgt_ok;
    logic split;
    logic [1:0] join_lr;
    logic [PG_W-1:0] init_pages;
    logic [TOTAL_W-1:0] total;
  } ctl_t;
endpackage

// ----- src/ffpa_cell.sv -----
// One table entry of the allocator: page count, used mark and scan token stage.
// Depends on ffpa_pkg.
`timescale 1ns / 1ps
module ffpa_cell #(
  parameter int IDX = 0
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  ffpa_pkg::ctl_t               ctl,
  input  ffpa_pkg::tok_t               tok_i,
  output ffpa_pkg::tok_t               tok_o,
  input  logic [ffpa_pkg::PG_W-1:0]    left_pages,
  input  logic                         left_used,
  input  logic                         left_mark,
  input  logic [ffpa_pkg::PG_W-1:0]    right_pages,
  input  logic                         right_used,
  input  logic                         right_mark,
  input  logic [ffpa_pkg::PG_W-1:0]    right2_pages,
  input  logic                         right2_used,
  output logic [ffpa_pkg::PG_W-1:0]    pages_o,
  output logic                         used_o,
  output logic                         mark_o
);
  logic [ffpa_pkg::PG_W-1:0] pages_r, pages_nxt;
  logic used_r, used_nxt;
  logic mark_r, past_r;
  ffpa_pkg::tok_t tok_r, tok_nxt;
  logic hit, fit, join_l, join_r;

  assign fit = !used_r && ({13'b0, pages_r} >= ctl.need);
  assign hit = tok_i.valid && !tok_i.found &&
               (ctl.is_free ? (ctl.tgt_ok && tok_i.off == ctl.tgt) : fit);
  assign join_l = (IDX != 0) && !left_used;
  assign join_r = (ffpa_pkg::TOTAL_W'(IDX + 1) < ctl.total) && !right_used;

  always_comb begin
    tok_nxt = tok_i;
    tok_nxt.off = tok_i.off + ffpa_pkg::OFF_W'(pages_r);
    if (hit) begin
      tok_nxt.found = 1'b1;
      tok_nxt.hit_off = tok_i.off;
      tok_nxt.split = !ctl.is_free && (pages_r != ctl.need[ffpa_pkg::PG_W-1:0]) && ctl.room;
      tok_nxt.join_lr = {join_r, join_l};
    end
  end

  always_comb begin
    pages_nxt = pages_r;
    used_nxt = used_r;
    if (ctl.init) begin
      pages_nxt = (IDX == 0) ? ctl.init_pages : '0;
      used_nxt = 1'b0;
    end else if (ctl.apply) begin
      if (!ctl.is_free) begin
        if (mark_r) begin
          used_nxt = 1'b1;
          if (ctl.split) pages_nxt = ctl.need[ffpa_pkg::PG_W-1:0];
        end else if (past_r && ctl.split) begin
          if (left_mark) begin
            pages_nxt = left_pages - ctl.need[ffpa_pkg::PG_W-1:0];
            used_nxt = 1'b0;
          end else begin
            pages_nxt = left_pages;
            used_nxt = left_used;
          end
        end
      end else begin
        case (ctl.join_lr)
          ffpa_pkg::JOIN_BOTH: begin
            if (right_mark) pages_nxt = pages_r + right_pages + right2_pages;
            else if (mark_r || past_r) begin
              pages_nxt = right2_pages;
              used_nxt = right2_used;
            end
          end
          ffpa_pkg::JOIN_LEFT: begin
            if (right_mark) pages_nxt = pages_r + right_pages;
            else if (mark_r || past_r) begin
              pages_nxt = right_pages;
              used_nxt = right_used;
            end
          end
          ffpa_pkg::JOIN_RIGHT: begin
            if (mark_r) begin
              pages_nxt = pages_r + right_pages;
              used_nxt = 1'b0;
            end else if (past_r) begin
              pages_nxt = right_pages;
              used_nxt = right_used;
            end
          end
          default: begin
            if (mark_r) used_nxt = 1'b0;
          end
        endcase
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pages_r <= (IDX == 0) ? ffpa_pkg::PAGES_RESET : '0;
      used_r <= 1'b0;
      mark_r <= 1'b0;
      past_r <= 1'b0;
      tok_r <= '0;
    end else begin
      pages_r <= pages_nxt;
      used_r <= used_nxt;
      tok_r <= tok_i.valid ? tok_nxt : '0;
      if (ctl.clr) begin
        mark_r <= 1'b0;
        past_r <= 1'b0;
      end else if (tok_i.valid) begin
        mark_r <= hit;
        past_r <= tok_i.found;
      end
    end
  end

  assign tok_o = tok_r;
  assign pages_o = pages_r;
  assign used_o = used_r;
  assign mark_o = mark_r;
endmodule

// ----- src/first_fit_page_allocator_core.sv -----
// Top level of the first-fit page allocator: APB registers, request control
// and the row of ffpa_cell entries. Depends on ffpa_pkg and the macros header.
//
// Channel   Direction  Handshake                  Payload
// in_       input      start & !busy              in_req_type, in_alloc_bytes, in_free_addr
// out_      output     out_valid, one cycle       out_result_addr, out_status
// cfg_      input      psel & penable & pwrite    paddr, pwdata (prdata on read)
//
// A request passes S_PREP and S_LAUNCH, then a scan token walks the cell row,
// one cell per cycle, and every cell updates at once in S_APPLY.
// A free outside the area skips the scan: S_LAUNCH goes straight to S_DONE.
// Reset (rst_n low, synchronous) leaves one free block of area_pages pages.
// The receiver cannot stall; busy is high from acceptance to the result.
`timescale 1ns / 1ps
`include "first_fit_page_allocator_core_macros.svh"
module first_fit_page_allocator_core #(
  parameter int MAX_BLOCKS = ffpa_pkg::MAX_BLOCKS_DEF,
  parameter int PAGE_BYTES = ffpa_pkg::PAGE_BYTES_DEF
) (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       start,
  output logic                       busy,
  input  logic                       in_req_type,
  input  logic [31:0]                in_alloc_bytes,
  input  logic [ffpa_pkg::AW-1:0]    in_free_addr,
  output logic                       out_valid,
  output logic [ffpa_pkg::AW-1:0]    out_result_addr,
  output logic [1:0]                 out_status,
  input  logic                       psel,
  input  logic                       penable,
  input  logic                       pwrite,
  input  logic [3:0]                 paddr,
  input  logic [63:0]                pwdata,
  output logic [63:0]                prdata,
  output logic                       pready
);
  localparam int SH = $clog2(PAGE_BYTES);
  localparam int AW = ffpa_pkg::AW;
  localparam int PG_W = ffpa_pkg::PG_W;
  localparam int OFF_W = ffpa_pkg::OFF_W;
  localparam int NEED_W = ffpa_pkg::NEED_W;
  localparam int TW = ffpa_pkg::TOTAL_W;

  ffpa_pkg::state_t state_r, state_nxt;
  logic [AW-1:0] cfg_area_base_r;
  logic [PG_W-1:0] cfg_area_pages_r;
  logic req_free_r;
  logic [31:0] bytes_r;
  logic [AW-1:0] addr_r;
  logic [NEED_W-1:0] need_r;
  logic [OFF_W-1:0] tgt_r;
  logic tgt_ok_r, range_ok_r;
  logic [TW-1:0] total_r;
  logic [AW-1:0] res_addr_r;
  ffpa_pkg::status_t res_status_r;
  ffpa_pkg::tok_t fin_r;
  logic cfg_wr, init_pulse, launch, exit_seen;
  logic [NEED_W-1:0] need_v;
  logic [AW:0] end_v, diff_v, pg1_v;
  ffpa_pkg::ctl_t ctl;
  ffpa_pkg::tok_t tok0;
  ffpa_pkg::tok_t tok_w [0:MAX_BLOCKS];
  logic [PG_W-1:0] pages_w [0:MAX_BLOCKS+1];
  logic used_w [0:MAX_BLOCKS+1];
  logic mark_w [0:MAX_BLOCKS];

  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite;
  assign init_pulse = cfg_wr && (paddr[3] == ffpa_pkg::REG_PAGES[3]);
  assign prdata = (paddr[3] == ffpa_pkg::REG_PAGES[3]) ? {44'b0, cfg_area_pages_r}
                                                       : {16'b0, cfg_area_base_r};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_area_base_r <= '0;
      cfg_area_pages_r <= ffpa_pkg::PAGES_RESET;
    end else if (cfg_wr) begin
      if (paddr[3] == ffpa_pkg::REG_PAGES[3]) cfg_area_pages_r <= pwdata[PG_W-1:0];
      else cfg_area_base_r <= pwdata[AW-1:0];
    end
  end

  assign need_v = NEED_W'(({1'b0, bytes_r} + NEED_W'(PAGE_BYTES - 1)) >> SH);
  assign pg1_v = (AW+1)'(cfg_area_pages_r) + (AW+1)'(1);
  assign end_v = {1'b0, cfg_area_base_r} + (pg1_v << SH);
  assign diff_v = {1'b0, addr_r} - {1'b0, cfg_area_base_r};
  assign launch = (state_r == ffpa_pkg::S_LAUNCH) && (!req_free_r || range_ok_r);
  assign exit_seen = tok_w[MAX_BLOCKS].valid;

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ffpa_pkg::S_IDLE:   if (start) state_nxt = ffpa_pkg::S_PREP;
      ffpa_pkg::S_PREP:   state_nxt = ffpa_pkg::S_LAUNCH;
      ffpa_pkg::S_LAUNCH: state_nxt = launch ? ffpa_pkg::S_SCAN : ffpa_pkg::S_DONE;
      ffpa_pkg::S_SCAN:   if (exit_seen) state_nxt = ffpa_pkg::S_APPLY;
      ffpa_pkg::S_APPLY:  state_nxt = ffpa_pkg::S_DONE;
      ffpa_pkg::S_DONE:   state_nxt = ffpa_pkg::S_IDLE;
      default:            state_nxt = ffpa_pkg::S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ffpa_pkg::S_IDLE;
      total_r <= TW'(1);
      fin_r <= '0;
    end else begin
      state_r <= state_nxt;
      if (exit_seen) fin_r <= tok_w[MAX_BLOCKS];
      if (init_pulse) total_r <= TW'(1);
      else if (state_r == ffpa_pkg::S_APPLY && fin_r.found) begin
        if (!req_free_r) total_r <= total_r + TW'(fin_r.split);
        else total_r <= total_r - TW'(fin_r.join_lr[0]) - TW'(fin_r.join_lr[1]);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (state_r == ffpa_pkg::S_IDLE && start) begin
      req_free_r <= in_req_type;
      bytes_r <= in_alloc_bytes;
      addr_r <= in_free_addr;
    end
    if (state_r == ffpa_pkg::S_PREP) begin
      need_r <= (need_v == '0) ? NEED_W'(1) : need_v;
      tgt_r <= OFF_W'(diff_v >> SH);
      tgt_ok_r <= (diff_v[SH-1:0] == '0);
      range_ok_r <= (addr_r[SH-1:0] == '0) && (addr_r > cfg_area_base_r) &&
                    ({1'b0, addr_r} < end_v);
    end
    if (state_r == ffpa_pkg::S_LAUNCH && !launch) begin
      res_addr_r <= '0;
      res_status_r <= ffpa_pkg::ST_RANGE;
    end else if (exit_seen) begin
      if (!tok_w[MAX_BLOCKS].found) begin
        res_addr_r <= '0;
        res_status_r <= req_free_r ? ffpa_pkg::ST_NOSTART : ffpa_pkg::ST_NOFIT;
      end else begin
        res_addr_r <= req_free_r ? '0 :
                      AW'(cfg_area_base_r + (AW'(tok_w[MAX_BLOCKS].hit_off) << SH));
        res_status_r <= ffpa_pkg::ST_OK;
      end
    end
  end

  always_comb begin
    ctl.init = init_pulse;
    ctl.clr = (state_r == ffpa_pkg::S_PREP);
    ctl.apply = (state_r == ffpa_pkg::S_APPLY) && fin_r.found;
    ctl.is_free = req_free_r;
    ctl.room = (total_r < TW'(MAX_BLOCKS));
    ctl.need = need_r;
    ctl.tgt = tgt_r;
    ctl.tgt_ok = tgt_ok_r;
    ctl.split = fin_r.split;
    ctl.join_lr = fin_r.join_lr;
    ctl.init_pages = pwdata[PG_W-1:0];
    ctl.total = total_r;
  end

  always_comb begin
    tok0 = '0;
    tok0.valid = launch;
    tok0.off = OFF_W'(1);
  end

  assign tok_w[0] = tok0;
  assign pages_w[MAX_BLOCKS] = '0;
  assign pages_w[MAX_BLOCKS+1] = '0;
  assign used_w[MAX_BLOCKS] = 1'b0;
  assign used_w[MAX_BLOCKS+1] = 1'b0;
  assign mark_w[MAX_BLOCKS] = 1'b0;

  for (genvar k = 0; k < MAX_BLOCKS; k++) begin : g_cell
    logic [PG_W-1:0] lp;
    logic lu, lm;
    if (k == 0) begin : g_first
      assign lp = '0;
      assign lu = 1'b0;
      assign lm = 1'b0;
    end else begin : g_rest
      assign lp = pages_w[k-1];
      assign lu = used_w[k-1];
      assign lm = mark_w[k-1];
    end
    ffpa_cell #(.IDX(k)) u_cell (
      .clk         (clk),
      .rst_n       (rst_n),
      .ctl         (ctl),
      .tok_i       (tok_w[k]),
      .tok_o       (tok_w[k+1]),
      .left_pages  (lp),
      .left_used   (lu),
      .left_mark   (lm),
      .right_pages (pages_w[k+1]),
      .right_used  (used_w[k+1]),
      .right_mark  (mark_w[k+1]),
      .right2_pages(pages_w[k+2]),
      .right2_used (used_w[k+2]),
      .pages_o     (pages_w[k]),
      .used_o      (used_w[k]),
      .mark_o      (mark_w[k])
    );
  end

  assign busy = (state_r != ffpa_pkg::S_IDLE);
  assign out_valid = (state_r == ffpa_pkg::S_DONE);
  assign out_result_addr = res_addr_r;
  assign out_status = res_status_r;

  `FFPA_ASSERT_NXT(a_one_result, out_valid, !out_valid)
  `FFPA_ASSERT_NXT(a_accept_busy, start && !busy, busy)
  `FFPA_ASSERT_IMP(a_total_range, 1'b1, total_r != '0 && total_r <= TW'(MAX_BLOCKS))
  `FFPA_ASSERT_IMP(a_addr_zero_on_fail, out_valid && out_status != ffpa_pkg::ST_OK,
                   out_result_addr == '0)
endmodule

// ----- verif/tb.sv -----
// Testbench for first_fit_page_allocator_core: directed and random allocate/free items.
// Results are checked against an in-bench predictor of the block table.
// Depends on ffpa_pkg and the core RTL.
`timescale 1ns / 1ps

class alloc_scoreboard;
  localparam int NBLK = 256;
  localparam longint unsigned PG = 4096;
  localparam longint unsigned AMASK = 64'hFFFF_FFFF_FFFF;

  longint unsigned base_addr;
  longint unsigned area_pg;
  bit [19:0] blk_pages[NBLK];
  bit blk_used[NBLK];
  int blk_total;
  logic [47:0] exp_addr_q[$];
  ffpa_pkg::status_t exp_status_q[$];
  int fails;

  function new();
    base_addr = 0;
    area_pg = 20'hFFFFF;
    fails = 0;
    table_clear();
  endfunction

  function void table_clear();
    foreach (blk_pages[k]) begin
      blk_pages[k] = 0;
      blk_used[k] = 0;
    end
    blk_pages[0] = area_pg[19:0];
    blk_total = 1;
  endfunction

  function void set_base(longint unsigned v);
    base_addr = v & AMASK;
  endfunction

  function void set_pages(longint unsigned v);
    area_pg = v & 64'hFFFFF;
    table_clear();
  endfunction

  function void drop_entries(int at, int n);
    for (int k = at; k + n < blk_total; k++) begin
      blk_pages[k] = blk_pages[k+n];
      blk_used[k] = blk_used[k+n];
    end
    for (int k = blk_total - n; k < blk_total; k++) begin
      blk_pages[k] = 0;
      blk_used[k] = 0;
    end
    blk_total -= n;
  endfunction

  function void take_pages(logic [31:0] nbytes, output logic [47:0] addr,
                           output ffpa_pkg::status_t st);
    longint unsigned need, ofs, rest;
    need = ({32'd0, nbytes} + PG - 1) / PG;
    if (need == 0) need = 1;
    ofs = 1;
    addr = '0;
    st = ffpa_pkg::ST_NOFIT;
    for (int i = 0; i < blk_total; i++) begin
      if (blk_used[i] || blk_pages[i] < need) begin
        ofs += blk_pages[i];
        continue;
      end
      rest = blk_pages[i] - need;
      blk_used[i] = 1;
      if (rest != 0 && blk_total < NBLK) begin
        for (int k = blk_total; k > i + 1; k--) begin
          blk_pages[k] = blk_pages[k-1];
          blk_used[k] = blk_used[k-1];
        end
        blk_total++;
        blk_pages[i] = need[19:0];
        blk_pages[i+1] = rest[19:0];
        blk_used[i+1] = 0;
      end
      addr = 48'((base_addr + ofs * PG) & AMASK);
      st = ffpa_pkg::ST_OK;
      return;
    end
  endfunction

  function ffpa_pkg::status_t release_block(logic [47:0] ptr);
    longint unsigned last, cur, p;
    int idx;
    bit jl, jr;
    p = {16'd0, ptr};
    last = base_addr + (area_pg + 1) * PG;
    cur = base_addr + PG;
    if (p % PG != 0 || !(p > base_addr && p < last)) return ffpa_pkg::ST_RANGE;
    for (idx = 0; idx < blk_total; idx++) begin
      if (cur == p) break;
      cur += PG * blk_pages[idx];
    end
    if (idx >= blk_total) return ffpa_pkg::ST_NOSTART;
    jl = idx != 0 && !blk_used[idx-1];
    jr = idx + 1 < blk_total && !blk_used[idx+1];
    if (jl && jr) begin
      blk_pages[idx-1] = blk_pages[idx-1] + blk_pages[idx] + blk_pages[idx+1];
      drop_entries(idx, 2);
    end else if (jl) begin
      blk_pages[idx-1] = blk_pages[idx-1] + blk_pages[idx];
      drop_entries(idx, 1);
    end else if (jr) begin
      blk_pages[idx] = blk_pages[idx] + blk_pages[idx+1];
      blk_used[idx] = 0;
      drop_entries(idx + 1, 1);
    end else begin
      blk_used[idx] = 0;
    end
    return ffpa_pkg::ST_OK;
  endfunction

  function logic [47:0] note_request(logic rtype, logic [31:0] nbytes, logic [47:0] faddr);
    logic [47:0] a;
    ffpa_pkg::status_t st;
    if (rtype == 1'b0) take_pages(nbytes, a, st);
    else begin
      a = '0;
      st = release_block(faddr);
    end
    exp_addr_q.push_back(a);
    exp_status_q.push_back(st);
    return (rtype == 1'b0 && st == ffpa_pkg::ST_OK) ? a : '0;
  endfunction

  task report(string msg);
    $display("mismatch: %s", msg);
    fails++;
  endtask

  task check_result(logic [47:0] a, logic [1:0] st);
    logic [47:0] ea;
    ffpa_pkg::status_t es;
    if (exp_addr_q.size() == 0) begin
      report($sformatf("unexpected item addr=%h status=%0d", a, st));
      return;
    end
    ea = exp_addr_q.pop_front();
    es = exp_status_q.pop_front();
    if (a !== ea) report($sformatf("result_addr %h, want %h", a, ea));
    if (st !== es) report($sformatf("status %0d, want %0d", st, es));
  endtask

  function int pending();
    return exp_addr_q.size();
  endfunction
endclass

module tb;
  logic clk = 0;
  logic rst_n = 0;
  logic start = 0;
  logic busy;
  logic in_req_type = 0;
  logic [31:0] in_alloc_bytes = '0;
  logic [ffpa_pkg::AW-1:0] in_free_addr = '0;
  logic out_valid;
  logic [ffpa_pkg::AW-1:0] out_result_addr;
  logic [1:0] out_status;
  logic psel = 0, penable = 0, pwrite = 0;
  logic [3:0] paddr = '0;
  logic [63:0] pwdata = '0;
  logic [63:0] prdata;
  logic pready;

  alloc_scoreboard sb = new();
  logic [47:0] live_q[$];
  bit idle_on = 1;

  first_fit_page_allocator_core u_dut (
    .clk(clk), .rst_n(rst_n), .start(start), .busy(busy),
    .in_req_type(in_req_type), .in_alloc_bytes(in_alloc_bytes),
    .in_free_addr(in_free_addr), .out_valid(out_valid),
    .out_result_addr(out_result_addr), .out_status(out_status),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
    .pwdata(pwdata), .prdata(prdata), .pready(pready)
  );

  always #5 clk = ~clk;

  always @(posedge clk) begin
    if (rst_n && out_valid) sb.check_result(out_result_addr, out_status);
  end

  initial begin
    #30ms;
    $display("RESULT: ERROR");
    $finish;
  end

  task automatic send_item(logic rtype, logic [31:0] nbytes, logic [47:0] faddr);
    logic [47:0] got;
    if (idle_on && $urandom_range(99) < 23) begin
      start <= 0;
      repeat ($urandom_range(1, 5)) @(posedge clk);
    end
    start <= 1;
    in_req_type <= rtype;
    in_alloc_bytes <= nbytes;
    in_free_addr <= faddr;
    forever begin
      @(negedge clk);
      if (!busy) break;
    end
    @(posedge clk);
    got = sb.note_request(rtype, nbytes, faddr);
    if (got != 0) live_q.push_back(got);
  endtask

  task automatic drain();
    start <= 0;
    while (sb.pending() != 0 || busy) @(posedge clk);
    repeat (8) @(posedge clk);
  endtask

  task automatic write_reg(logic [3:0] addr, logic [63:0] val);
    drain();
    psel <= 1;
    penable <= 0;
    pwrite <= 1;
    paddr <= addr;
    pwdata <= val;
    @(posedge clk);
    penable <= 1;
    @(posedge clk);
    psel <= 0;
    penable <= 0;
    pwrite <= 0;
    if (addr == ffpa_pkg::REG_BASE) sb.set_base(val);
    else begin
      sb.set_pages(val);
      live_q.delete();
    end
    @(posedge clk);
  endtask

  task automatic rand_item();
    int sel;
    int k;
    longint unsigned p;
    sel = $urandom_range(99);
    p = $urandom_range(1, (sb.area_pg == 0) ? 1 : int'(sb.area_pg));
    if (sel < 55) begin
      if ($urandom_range(99) < 12)
        send_item(1'b0, $urandom(), 48'({$urandom(), $urandom()}));
      else send_item(1'b0, $urandom_range(0, 4096 * 12), 48'({$urandom(), $urandom()}));
    end else if (sel < 85 && live_q.size() != 0) begin
      k = $urandom_range(0, live_q.size() - 1);
      send_item(1'b1, $urandom(), live_q[k]);
      live_q.delete(k);
    end else if (sel < 93) begin
      send_item(1'b1, $urandom(), 48'(sb.base_addr + p * 4096));
    end else if (sel < 97) begin
      send_item(1'b1, $urandom(), 48'(sb.base_addr + p * 4096 + $urandom_range(1, 4095)));
    end else begin
      send_item(1'b1, $urandom(), 48'({$urandom(), $urandom()}));
    end
  endtask

  initial begin
    logic [47:0] a0, a1, a2;
    repeat (12) @(posedge clk);
    rst_n <= 1;
    @(posedge clk);

    send_item(1'b0, 32'd0, 48'hFFFF_FFFF_FFFF);
    send_item(1'b0, 32'd1, '0);
    send_item(1'b0, 32'd4096, '0);
    send_item(1'b0, 32'd4097, '0);
    send_item(1'b0, 32'hFFFF_FFFF, '0);
    send_item(1'b1, 32'hFFFF_FFFF, 48'h0);
    send_item(1'b1, '0, 48'h2001);
    send_item(1'b1, '0, 48'h1_0000_0000);
    send_item(1'b1, '0, 48'hFFFF_FFFF_F000);
    send_item(1'b1, '0, 48'h3000);
    a0 = 48'h1000; a1 = 48'h2000; a2 = 48'h3000;
    send_item(1'b1, '0, a1);
    send_item(1'b1, '0, a1);
    send_item(1'b1, '0, a0);
    send_item(1'b1, '0, 48'h4000);
    send_item(1'b1, '0, a2);
    live_q.delete();

    write_reg(ffpa_pkg::REG_BASE, 64'hFFFF_FFFF_F000);
    write_reg(ffpa_pkg::REG_PAGES, 64'd3);
    send_item(1'b0, 32'd8192, '0);
    send_item(1'b0, 32'd4096, '0);
    send_item(1'b0, 32'd1, '0);
    send_item(1'b1, '0, 48'h0000_0000_1000);
    send_item(1'b1, '0, 48'hFFFF_FFFF_F000);
    write_reg(ffpa_pkg::REG_PAGES, 64'd0);
    send_item(1'b0, 32'd0, '0);
    send_item(1'b1, '0, 48'hFFFF_FFFF_F000);
    write_reg(ffpa_pkg::REG_PAGES, 64'd1);
    send_item(1'b0, 32'd0, '0);
    send_item(1'b0, 32'd0, '0);

    write_reg(ffpa_pkg::REG_BASE, 64'h0);
    write_reg(ffpa_pkg::REG_PAGES, 64'd300);
    idle_on = 0;
    repeat (262) send_item(1'b0, $urandom_range(0, 4096), 48'({$urandom(), $urandom()}));
    repeat (40) rand_item();
    idle_on = 1;

    for (int ph = 0; ph < 5; ph++) begin
      write_reg(ffpa_pkg::REG_BASE, {$urandom(), $urandom()} & 64'hFFFF_FFFF_F000);
      if (ph == 4) write_reg(ffpa_pkg::REG_PAGES, 64'hFFFFF);
      else write_reg(ffpa_pkg::REG_PAGES, 64'($urandom_range(8, 160)));
      repeat (45) rand_item();
    end

    drain();
    repeat (300) @(posedge clk);
    if (sb.fails == 0) $display("RESULT: OK");
    else $display("RESULT: ERROR");
    $finish;
  end
endmodule
